// ===== rtl/tla_pkg.sv =====
`timescale 1ns / 1ps

package tla_pkg;

  localparam logic [1:0]  MODE_ASSIGNED = 2'd1;
  localparam logic [1:0]  MODE_INVALID  = 2'd3;
  localparam logic [31:0] REJECT_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] WATCHDOG_RST  = 32'd1000000;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_RENEW   = 3'd1,
    ST_INVALID = 3'd2,
    ST_STALE   = 3'd3,
    ST_QUERY   = 3'd4
  } tla_status_e;

  typedef struct packed {
    logic               kind;
    logic signed [63:0] now_time;
    logic        [47:0] steady_time;
    logic signed [63:0] issued_time;
    logic signed [63:0] lease_length;
    logic        [31:0] epoch;
    logic        [31:0] revision_no;
    logic        [31:0] task_number;
    logic        [1:0]  task_mode;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } tla_in_t;

  typedef struct packed {
    tla_status_e        status;
    logic        [31:0] reject_total;
    logic               active;
    logic        [31:0] out_epoch;
    logic        [31:0] out_revision;
    logic        [31:0] out_task;
    logic        [1:0]  out_mode;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [62:0] out_issued;
    logic        [62:0] out_expiry;
  } tla_out_t;

  // Last accepted task. System times are kept as 63-bit magnitudes (only
  // positive values are ever stored); the steady receive time is 48 bits.
  typedef struct packed {
    logic               have_task;
    logic        [31:0] epoch;
    logic        [31:0] revision;
    logic        [31:0] task_id;
    logic        [1:0]  mode;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic        [62:0] issued;
    logic        [62:0] lease;
    logic        [62:0] expiry;
    logic        [47:0] receive;
  } tla_kept_t;

  typedef struct packed {
    logic        store;
    logic [62:0] expiry;
  } tla_upd_t;

endpackage

// ===== rtl/task_lease_admission.sv =====
`timescale 1ns / 1ps
// A word accepted into the input stage has its result word registered once
//   the result register is free or being drained. Throughput: one word per
//   cycle unless out_ready_i stalls; the input and result registers form a
//   two-stage pipe, so an empty input stage takes a word while a result waits.
// Reset: rst_ni low clears both pipe stages, the kept task, the reject
//   count, and sets the watchdog register to 1000000 us.
module task_lease_admission (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tla_pkg::tla_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tla_pkg::tla_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i
);
  import tla_pkg::*;

  // Input stage
  logic        s1_valid_q;
  tla_in_t     s1_item_q;
  // Result stage
  logic        out_valid_q;
  tla_out_t    out_data_q;

  logic        advance;   // result register free or being drained this cycle
  logic        step;      // stage-1 word decided and retired this cycle
  logic        in_take;

  tla_kept_t   kept;
  logic [31:0] reject_cnt;
  logic [31:0] watchdog;
  tla_out_t    res;
  tla_upd_t    upd;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Decision logic reads the kept task as it stands before this word; state
  // updates land at the same edge the result is registered, so the next word
  // sees them with no bubble.
  tla_decide u_decide (
    .item_i       (s1_item_q),
    .kept_i       (kept),
    .reject_cnt_i (reject_cnt),
    .watchdog_i   (watchdog),
    .res_o        (res),
    .upd_o        (upd)
  );

  tla_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (s1_item_q),
    .upd_i         (upd),
    .reject_next_i (res.reject_total),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kept_o        (kept),
    .reject_cnt_o  (reject_cnt),
    .watchdog_o    (watchdog)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/tla_decide.sv =====
`timescale 1ns / 1ps

module tla_decide (
  input  tla_pkg::tla_in_t   item_i,
  input  tla_pkg::tla_kept_t kept_i,
  input  logic [31:0]        reject_cnt_i,
  input  logic [31:0]        watchdog_i,
  output tla_pkg::tla_out_t  res_o,
  output tla_pkg::tla_upd_t  upd_o
);
  import tla_pkg::*;

  logic        env_bad;
  logic        task_bad;
  logic [63:0] sum;
  logic        lease_ovf;
  logic        expired;
  logic        same_ep;
  logic        same_body;
  logic        not_newer;
  logic [47:0] gap;
  logic        wd_late;
  logic        live;
  logic        reject;
  tla_status_e status;

  always_comb begin
    task_bad = (item_i.task_mode == MODE_ASSIGNED) ? (item_i.task_number == 32'd0)
                                                   : (item_i.task_number != 32'd0);
    env_bad = item_i.issued_time[63] || (item_i.issued_time == 64'sd0) ||
              item_i.lease_length[63] || (item_i.lease_length == 64'sd0) ||
              (item_i.epoch == 32'd0) || (item_i.revision_no == 32'd0) ||
              (item_i.task_mode == MODE_INVALID) || task_bad;
    // Both operands are positive here, so a carry into bit 63 is overflow.
    sum       = {1'b0, item_i.issued_time[62:0]} + {1'b0, item_i.lease_length[62:0]};
    lease_ovf = sum[63];
    expired   = (sum[62:0] <= item_i.now_time[62:0]);
    same_ep   = (item_i.epoch == kept_i.epoch);
    not_newer = (item_i.issued_time[62:0] <= kept_i.issued);
    same_body = (item_i.task_number == kept_i.task_id) &&
                (item_i.task_mode == kept_i.mode) &&
                (item_i.target_x == kept_i.tx) && (item_i.target_y == kept_i.ty) &&
                (item_i.target_z == kept_i.tz) &&
                (item_i.lease_length[62:0] == kept_i.lease);

    status = ST_NEW;
    if (item_i.now_time[63] || env_bad) begin
      status = ST_INVALID;
    end else if (lease_ovf || expired) begin
      status = ST_STALE;
    end else if (kept_i.have_task) begin
      if (same_ep) begin
        if (item_i.revision_no < kept_i.revision) begin
          status = ST_STALE;
        end else if (item_i.revision_no == kept_i.revision) begin
          if (!same_body) begin
            status = ST_INVALID;
          end else if (not_newer) begin
            status = ST_STALE;
          end else begin
            status = ST_RENEW;
          end
        end
      end else if (not_newer) begin
        status = ST_STALE;
      end
    end

    reject = !item_i.kind && ((status == ST_INVALID) || (status == ST_STALE));

    // Query: lease by system time, watchdog by steady time. Steady time that
    // went backwards counts as no gap.
    gap     = item_i.steady_time - kept_i.receive;
    wd_late = (item_i.steady_time > kept_i.receive) && (gap > {16'd0, watchdog_i});
    live    = kept_i.have_task && !item_i.now_time[63] &&
              (item_i.now_time[62:0] < kept_i.expiry) && !wd_late;

    res_o = '0;
    res_o.reject_total = (reject && (reject_cnt_i != REJECT_MAX)) ? reject_cnt_i + 32'd1
                                                                 : reject_cnt_i;
    if (item_i.kind) begin
      res_o.status = ST_QUERY;
      if (live) begin
        res_o.active       = 1'b1;
        res_o.out_epoch    = kept_i.epoch;
        res_o.out_revision = kept_i.revision;
        res_o.out_task     = kept_i.task_id;
        res_o.out_mode     = kept_i.mode;
        res_o.out_x        = kept_i.tx;
        res_o.out_y        = kept_i.ty;
        res_o.out_z        = kept_i.tz;
        res_o.out_issued   = kept_i.issued;
        res_o.out_expiry   = kept_i.expiry;
      end
    end else begin
      res_o.status = status;
    end

    upd_o.store  = !item_i.kind && ((status == ST_NEW) || (status == ST_RENEW));
    upd_o.expiry = sum[62:0];
  end

endmodule

// ===== rtl/tla_state.sv =====
`timescale 1ns / 1ps

module tla_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tla_pkg::tla_in_t   item_i,
  input  tla_pkg::tla_upd_t  upd_i,
  input  logic [31:0]        reject_next_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  output tla_pkg::tla_kept_t kept_o,
  output logic [31:0]        reject_cnt_o,
  output logic [31:0]        watchdog_o
);
  import tla_pkg::*;

  tla_kept_t   kept_q;
  logic [31:0] reject_q;
  logic [31:0] watchdog_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q     <= '0;
      reject_q   <= '0;
      watchdog_q <= WATCHDOG_RST;
    end else begin
      if (cfg_we_i) begin
        watchdog_q <= cfg_wdata_i;
      end
      if (step_i) begin
        reject_q <= reject_next_i;
        if (upd_i.store) begin
          kept_q.have_task <= 1'b1;
          kept_q.epoch     <= item_i.epoch;
          kept_q.revision  <= item_i.revision_no;
          kept_q.task_id   <= item_i.task_number;
          kept_q.mode      <= item_i.task_mode;
          kept_q.tx        <= item_i.target_x;
          kept_q.ty        <= item_i.target_y;
          kept_q.tz        <= item_i.target_z;
          kept_q.issued    <= item_i.issued_time[62:0];
          kept_q.lease     <= item_i.lease_length[62:0];
          kept_q.expiry    <= upd_i.expiry;
          kept_q.receive   <= item_i.steady_time;
        end
      end
    end
  end

  assign kept_o       = kept_q;
  assign reject_cnt_o = reject_q;
  assign watchdog_o   = watchdog_q;

endmodule

// ===== rtl/tla_checker.sv =====
`timescale 1ns / 1ps

module tla_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tla_pkg::tla_out_t out_data_o
);
  import tla_pkg::*;

  logic [31:0] last_total_q;
  logic        out_take;
  logic        is_reject;

  assign out_take  = out_valid_o && out_ready_i;
  assign is_reject = (out_data_o.status == ST_INVALID) || (out_data_o.status == ST_STALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_total_q <= '0;
    end else if (out_take) begin
      last_total_q <= out_data_o.reject_total;
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // Input only backs up when a result is waiting downstream.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with no result waiting");

  // A rejection adds one to the count unless it is full.
  a_reject_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && is_reject && (last_total_q != REJECT_MAX)
      |-> out_data_o.reject_total == last_total_q + 32'd1)
    else $error("reject count did not step on a rejection");

  // Accepts and queries leave the count alone.
  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !is_reject |-> out_data_o.reject_total == last_total_q)
    else $error("reject count moved without a rejection");

endmodule

bind task_lease_admission tla_checker u_tla_checker (.*);
